### design/mpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpsd_pkg;

	localparam int PwmWidth = 16;
	localparam int CountWidth = 17;
	localparam int ThresholdWidth = 15;
	localparam int TimeoutWidth = 16;
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth = 16;

	localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_RESET = 1'b1
	} command_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_PWM_THRESHOLD     = 2'd0,
		CFG_STALL_TIMEOUT     = 2'd1,
		CFG_AUTO_RESET_ENABLE = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic                        command;
		logic signed [PwmWidth-1:0]  pwm_left;
		logic signed [PwmWidth-1:0]  pwm_right;
		logic                        emergency_stop;
	} item_t;

	typedef struct packed {
		logic alert_left;
		logic alert_right;
		logic idle_left;
		logic idle_right;
		logic controller_reset;
	} result_t;

	typedef struct packed {
		logic                  hit;
		logic [CountWidth-1:0] count_next;
	} wheel_t;

endpackage
`default_nettype wire

### design/mpsd_wheel.sv
`timescale 1ns / 1ps
`default_nettype none
module mpsd_wheel (
	input  logic signed [mpsd_pkg::PwmWidth-1:0]    prev,
	input  logic signed [mpsd_pkg::PwmWidth-1:0]    cur,
	input  logic [mpsd_pkg::ThresholdWidth-1:0]     threshold,
	input  logic [mpsd_pkg::TimeoutWidth-1:0]       timeout,
	input  logic [mpsd_pkg::CountWidth-1:0]         count,
	output mpsd_pkg::wheel_t                        wheel
);

	localparam int CmpWidth = mpsd_pkg::PwmWidth + 1;

	logic signed [CmpWidth-1:0] th_pos;
	logic signed [CmpWidth-1:0] th_neg;
	logic signed [CmpWidth-1:0] prev_x;
	logic signed [CmpWidth-1:0] cur_x;
	logic                       sat;

	always_comb begin
		th_pos = signed'(CmpWidth'(threshold));
		th_neg = -th_pos;
		prev_x = CmpWidth'(prev);
		cur_x  = CmpWidth'(cur);
		sat = ((prev_x > th_pos) && (cur_x > th_pos)) ||
			((prev_x < th_neg) && (cur_x < th_neg));
		// counter is read before it advances
		wheel.hit = sat && (count > mpsd_pkg::CountWidth'(timeout));
		if (!sat) begin
			wheel.count_next = '0;
		end else if (count == mpsd_pkg::CountMax) begin
			wheel.count_next = count;
		end else begin
			wheel.count_next = count + 1'b1;
		end
	end

endmodule
`default_nettype wire

### design/motor_pwm_stall_detector.sv
// Motor stall detector: flags a wheel whose drive value stays saturated.
// Item channel (item_valid / item_stall / item): one tick sample or one
// software reset command per transfer. Result channel (result_valid /
// result_stall / result): exactly one result per item, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
// is always high; write only while no item is in flight.
// Flow: an item is held in the input register, then its result is loaded
// into the output register, which raises result_valid. Throughput: one
// item per cycle while result_stall is low, set by the single
// compare-and-count step between the two registers.
// When result_stall is high with result_valid set, the output register holds;
// the input register still fills once, after which item_stall follows result_stall.
// Reset: registers return to threshold 200, timeout 80, auto reset off,
// counters and previous samples zero, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
module motor_pwm_stall_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  mpsd_pkg::item_t                        item,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output mpsd_pkg::result_t                      result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mpsd_pkg::CfgIndexWidth-1:0]     cfg_index,
	input  logic [mpsd_pkg::CfgDataWidth-1:0]      cfg_data
);

	logic                                    valid_s1;
	mpsd_pkg::item_t                         item_s1;
	logic                                    out_free;
	logic                                    move_s1;

	logic [mpsd_pkg::ThresholdWidth-1:0]     threshold_q;
	logic [mpsd_pkg::TimeoutWidth-1:0]       timeout_q;
	logic                                    auto_reset_q;

	logic signed [mpsd_pkg::PwmWidth-1:0]    prev_left_q;
	logic signed [mpsd_pkg::PwmWidth-1:0]    prev_right_q;
	logic [mpsd_pkg::CountWidth-1:0]         count_left_q;
	logic [mpsd_pkg::CountWidth-1:0]         count_right_q;
	logic                                    episode_done_q;

	mpsd_pkg::wheel_t                        wheel_left;
	mpsd_pkg::wheel_t                        wheel_right;
	mpsd_pkg::result_t                       res_d;
	logic [mpsd_pkg::CountWidth-1:0]         count_left_d;
	logic [mpsd_pkg::CountWidth-1:0]         count_right_d;
	logic                                    episode_done_d;
	logic                                    take_sample;

	assign cfg_ready  = 1'b1;
	assign out_free   = !result_valid || !result_stall;
	assign move_s1    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	mpsd_wheel u_left (
		.prev      (prev_left_q),
		.cur       (item_s1.pwm_left),
		.threshold (threshold_q),
		.timeout   (timeout_q),
		.count     (count_left_q),
		.wheel     (wheel_left)
	);

	mpsd_wheel u_right (
		.prev      (prev_right_q),
		.cur       (item_s1.pwm_right),
		.threshold (threshold_q),
		.timeout   (timeout_q),
		.count     (count_right_q),
		.wheel     (wheel_right)
	);

	always_comb begin
		res_d          = '0;
		count_left_d   = count_left_q;
		count_right_d  = count_right_q;
		episode_done_d = episode_done_q;
		take_sample    = 1'b0;
		if (item_s1.command == mpsd_pkg::CMD_RESET) begin
			count_left_d          = '0;
			count_right_d         = '0;
			res_d.controller_reset = 1'b1;
		end else if (item_s1.emergency_stop) begin
			// auto reset fires once per stop episode
			if (auto_reset_q && !episode_done_q) begin
				episode_done_d         = 1'b1;
				count_left_d           = '0;
				count_right_d          = '0;
				res_d.controller_reset = 1'b1;
			end
		end else begin
			take_sample       = 1'b1;
			episode_done_d    = 1'b0;
			res_d.alert_left  = wheel_left.hit;
			res_d.alert_right = wheel_right.hit;
			res_d.idle_left   = wheel_left.hit && auto_reset_q;
			res_d.idle_right  = wheel_right.hit && auto_reset_q;
			if (wheel_left.hit || wheel_right.hit) begin
				count_left_d  = '0;
				count_right_d = '0;
			end else begin
				count_left_d  = wheel_left.count_next;
				count_right_d = wheel_right.count_next;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q    <= '0;
			prev_right_q   <= '0;
			count_left_q   <= '0;
			count_right_q  <= '0;
			episode_done_q <= 1'b0;
		end else if (move_s1) begin
			count_left_q   <= count_left_d;
			count_right_q  <= count_right_d;
			episode_done_q <= episode_done_d;
			if (take_sample) begin
				prev_left_q  <= item_s1.pwm_left;
				prev_right_q <= item_s1.pwm_right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= mpsd_pkg::ThresholdWidth'(200);
			timeout_q    <= mpsd_pkg::TimeoutWidth'(80);
			auto_reset_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mpsd_pkg::CFG_PWM_THRESHOLD: begin
					threshold_q <= cfg_data[mpsd_pkg::ThresholdWidth-1:0];
				end
				mpsd_pkg::CFG_STALL_TIMEOUT: begin
					timeout_q <= cfg_data[mpsd_pkg::TimeoutWidth-1:0];
				end
				mpsd_pkg::CFG_AUTO_RESET_ENABLE: begin
					auto_reset_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire
